// ===== rtl/core/pgt_pkg.sv =====
// Shared constants for the polar Gaussian transform.
// Used by the front end, the queue, the back end and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pgt_pkg;

  localparam int UNIFORM_BITS_DEF = 16;

  localparam int MANT_BITS = 31;
  localparam int LOG_STEPS = 30;
  localparam int SHIFT_BITS = 6;
  localparam int QUOT_BITS = 33;
  localparam int NLOG_BITS = 37;
  localparam int ROOT_BITS = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_IDX_BITS = 8;

  localparam logic [23:0] LN2_Q24 = 24'd11629080;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MEAN_OFFSET = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPREAD_SCALE = 8'd1;

  localparam logic [15:0] SPREAD_RESET = 16'd4096;

endpackage

`default_nettype wire

// ===== rtl/core/polar_gaussian_transform_top.sv =====
// Polar Gaussian transform: each uniform pair that passes the rejection test gives two Gaussian samples.
// The second sample of a pair is formed by a further pass through the SMUL1, SMUL2 and SOUT states.
// A new pair is taken only after the second sample of the last one is loaded into the result register,
// as the 30-step log loop, 33-step divider and 32-step square root share one back-end sequencer.
// Synchronous active-low reset clears control state; mean_offset resets to 0,
// spread_scale to 1.0. Depends on pgt_pkg, pgt_front, pgt_queue and pgt_back.
`timescale 1ns / 1ps
`default_nettype none

module polar_gaussian_transform_top
  import pgt_pkg::*;
#(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  [UNIFORM_BITS-1:0]   in_uniform_a,
  input  wire  [UNIFORM_BITS-1:0]   in_uniform_b,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [SAMPLE_BITS-1:0]    out_gauss_sample,
  output logic                      out_pair_end,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [CFG_IDX_BITS-1:0]   cfg_index,
  input  wire  [15:0]               cfg_data
);

  localparam int N = UNIFORM_BITS;
  localparam int QW = 4 * N - 2;

  logic [15:0] mean_offset_r, spread_scale_r;
  logic          q_full, q_empty, q_push, q_pop;
  logic [N-1:0]  f_a, f_b;
  logic [2*N-3:0] f_v;
  logic [QW-1:0] q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_offset_r <= 16'd0;
      spread_scale_r <= SPREAD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MEAN_OFFSET) begin
        mean_offset_r <= cfg_data;
      end else if (cfg_index == CFG_SPREAD_SCALE) begin
        spread_scale_r <= cfg_data;
      end
    end
  end

  pgt_front #(.UNIFORM_BITS(N)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_uniform_a (in_uniform_a),
    .in_uniform_b (in_uniform_b),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_a          (f_a),
    .q_b          (f_b),
    .q_v          (f_v)
  );

  pgt_queue #(.DATA_BITS(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_a, f_b, f_v}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  pgt_back #(.UNIFORM_BITS(N)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_a              (q_out[QW-1:QW-N]),
    .q_b              (q_out[QW-N-1:2*N-2]),
    .q_v              (q_out[2*N-3:0]),
    .mean_offset      (mean_offset_r),
    .spread_scale     (spread_scale_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_gauss_sample (out_gauss_sample),
    .out_pair_end     (out_pair_end)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pgt_front.sv =====
// Front end: registers an input pair, forms W = a^2 + b^2 and drops rejected pairs.
// Depends on pgt_pkg; feeds pgt_queue.
`timescale 1ns / 1ps
`default_nettype none

module pgt_front
  import pgt_pkg::*;
#(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [UNIFORM_BITS-1:0]       in_uniform_a,
  input  wire  [UNIFORM_BITS-1:0]       in_uniform_b,
  input  wire                           q_full,
  output logic                          q_push,
  output logic [UNIFORM_BITS-1:0]       q_a,
  output logic [UNIFORM_BITS-1:0]       q_b,
  output logic [2*UNIFORM_BITS-3:0]     q_v
);

  localparam int N = UNIFORM_BITS;
  localparam int F = N - 1;

  logic         vld_r, vld_nxt;
  logic [N-1:0] a_r, b_r;
  logic [N-1:0] ma, mb;
  logic [2*N-1:0] sum;
  logic         reject, moved, in_acc;

  always_comb begin
    ma = a_r[N-1] ? (~a_r + 1'b1) : a_r;
    mb = b_r[N-1] ? (~b_r + 1'b1) : b_r;
    sum = ({N'(0), ma} * {N'(0), ma}) + ({N'(0), mb} * {N'(0), mb});
    reject = (sum == '0) || (sum[2*N-1:2*F] != '0);
    moved = reject || !q_full;
    in_stall = vld_r && !moved;
    in_acc = in_valid && !in_stall;
    vld_nxt = in_acc || (vld_r && !moved);
    q_push = vld_r && !reject && !q_full;
    q_a = a_r;
    q_b = b_r;
    q_v = sum[2*F-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r <= in_uniform_a;
      b_r <= in_uniform_b;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pgt_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
// Depends on pgt_pkg for UNIFORM_BITS_DEF in the default data width.
`timescale 1ns / 1ps
`default_nettype none

module pgt_queue
  import pgt_pkg::*;
#(
  parameter int DATA_BITS = 4 * UNIFORM_BITS_DEF - 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  wire  [DATA_BITS-1:0] push_data,
  input  wire                  pop,
  output logic [DATA_BITS-1:0] pop_data,
  output logic                 full,
  output logic                 empty
);

  logic [DATA_BITS-1:0] mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pgt_back.sv =====
// Back end: log by repeated squaring, restoring divide, digit square root and scaling.
// Depends on pgt_pkg; drains pgt_queue and drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module pgt_back
  import pgt_pkg::*;
#(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           q_empty,
  output logic                          q_pop,
  input  wire  [UNIFORM_BITS-1:0]       q_a,
  input  wire  [UNIFORM_BITS-1:0]       q_b,
  input  wire  [2*UNIFORM_BITS-3:0]     q_v,
  input  wire  [15:0]                   mean_offset,
  input  wire  [15:0]                   spread_scale,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [SAMPLE_BITS-1:0]        out_gauss_sample,
  output logic                          out_pair_end
);

  localparam int N = UNIFORM_BITS;
  localparam int F = N - 1;
  localparam int VW = 2 * F;
  localparam int PW = $clog2(VW);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_NORM  = 11'b000_0000_0010,
    ST_LOG   = 11'b000_0000_0100,
    ST_MULN  = 11'b000_0000_1000,
    ST_SUMN  = 11'b000_0001_0000,
    ST_DIV   = 11'b000_0010_0000,
    ST_SHIFT = 11'b000_0100_0000,
    ST_SQRT  = 11'b000_1000_0000,
    ST_SMUL1 = 11'b001_0000_0000,
    ST_SMUL2 = 11'b010_0000_0000,
    ST_SOUT  = 11'b100_0000_0000
  } state_t;

  state_t st_r, st_nxt;

  logic [N-1:0]            a_r, b_r;
  logic [VW-1:0]           v_r;
  logic [MANT_BITS-1:0]    m_r, x_r;
  logic [SHIFT_BITS-1:0]   s_r;
  logic [LOG_STEPS-1:0]    frac_r;
  logic [5:0]              cnt_r, cnt_nxt;
  logic [41:0]             ph_r, pl_r;
  logic [MANT_BITS-1:0]    rem_r;
  logic [QUOT_BITS-1:0]    dq_r;
  logic [63:0]             srem_r, root_r, bit_r;
  logic [32:0]             t_r;
  logic [34:0]             mag_r;
  logic                    neg_r, sel_b_r;
  logic                    out_valid_r;
  logic [SAMPLE_BITS-1:0]  sample_r;
  logic                    pair_end_r;

  logic [PW-1:0]           p;
  logic [63:0]             v64, m64;
  logic [2*MANT_BITS-1:0]  sq;
  logic [31:0]             xs;
  logic [35:0]             lneg;
  logic [59:0]             nfull;
  logic [NLOG_BITS-1:0]    n;
  logic [31:0]             trial;
  logic [127:0]            wide;
  logic [63:0]             trial_s;
  logic [N-1:0]            usel, mag_u;
  logic [N+31:0]           prod1;
  logic [48:0]             prod2;
  logic [36:0]             ssum;
  logic [SAMPLE_BITS-1:0]  sat;
  logic                    out_ld;

  always_comb begin
    p = '0;
    for (int i = 0; i < VW; i++) begin
      if (v_r[i]) begin
        p = PW'(i);
      end
    end
    v64 = 64'(v_r);
    m64 = (p <= PW'(30)) ? (v64 << (30 - 32'(p))) : (v64 >> (32'(p) - 30));
    sq = {{MANT_BITS{1'b0}}, x_r} * {{MANT_BITS{1'b0}}, x_r};
    xs = sq[61:30];
    lneg = {s_r, 30'b0} - {6'b0, frac_r};
    nfull = {ph_r, 18'b0} + {18'b0, pl_r};
    n = nfull[59:23];
    trial = {rem_r, dq_r[QUOT_BITS-1]};
    wide = {95'b0, dq_r} << s_r;
    trial_s = root_r + bit_r;
    usel = sel_b_r ? b_r : a_r;
    mag_u = usel[N-1] ? (~usel + 1'b1) : usel;
    prod1 = {32'b0, mag_u} * {{N{1'b0}}, root_r[31:0]};
    prod2 = {16'b0, t_r} * {33'b0, spread_scale};
    ssum = {{21{mean_offset[15]}}, mean_offset} + (neg_r ? (~{2'b0, mag_r} + 1'b1) : {2'b0, mag_r});
    if (!ssum[36] && (ssum[35:15] != '0)) begin
      sat = 16'h7FFF;
    end else if (ssum[36] && (ssum[35:15] != '1)) begin
      sat = 16'h8000;
    end else begin
      sat = ssum[15:0];
    end
    out_ld = (st_r == ST_SOUT) && (!out_valid_r || !out_stall);
    q_pop = (st_r == ST_IDLE) && !q_empty;
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          st_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        st_nxt = ST_LOG;
        cnt_nxt = '0;
      end
      ST_LOG: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'(LOG_STEPS - 1)) begin
          st_nxt = ST_MULN;
        end
      end
      ST_MULN: st_nxt = ST_SUMN;
      ST_SUMN: begin
        st_nxt = ST_DIV;
        cnt_nxt = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'(QUOT_BITS - 1)) begin
          st_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: st_nxt = ST_SQRT;
      ST_SQRT: begin
        if (bit_r[0]) begin
          st_nxt = ST_SMUL1;
        end
      end
      ST_SMUL1: st_nxt = ST_SMUL2;
      ST_SMUL2: st_nxt = ST_SOUT;
      ST_SOUT: begin
        if (out_ld) begin
          st_nxt = sel_b_r ? ST_IDLE : ST_SMUL1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      sel_b_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_ld || (out_valid_r && out_stall);
      if (q_pop) begin
        sel_b_r <= 1'b0;
      end else if (out_ld) begin
        sel_b_r <= ~sel_b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        a_r <= q_a;
        b_r <= q_b;
        v_r <= q_v;
      end
      ST_NORM: begin
        m_r <= m64[MANT_BITS-1:0];
        x_r <= m64[MANT_BITS-1:0];
        s_r <= SHIFT_BITS'(VW) - SHIFT_BITS'(p);
        frac_r <= '0;
      end
      ST_LOG: begin
        frac_r <= {frac_r[LOG_STEPS-2:0], xs[31]};
        x_r <= xs[31] ? xs[31:1] : xs[30:0];
      end
      ST_MULN: begin
        ph_r <= {24'b0, lneg[35:18]} * {18'b0, LN2_Q24};
        pl_r <= {24'b0, lneg[17:0]} * {18'b0, LN2_Q24};
      end
      ST_SUMN: begin
        rem_r <= {1'b0, n[36:7]};
        dq_r <= {n[6:0], 26'b0};
      end
      ST_DIV: begin
        if (trial >= {1'b0, m_r}) begin
          rem_r <= MANT_BITS'(trial - {1'b0, m_r});
          dq_r <= {dq_r[QUOT_BITS-2:0], 1'b1};
        end else begin
          rem_r <= trial[MANT_BITS-1:0];
          dq_r <= {dq_r[QUOT_BITS-2:0], 1'b0};
        end
      end
      ST_SHIFT: begin
        srem_r <= (wide[127:64] != '0) ? '1 : wide[63:0];
        root_r <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
      end
      ST_SQRT: begin
        if (srem_r >= trial_s) begin
          srem_r <= srem_r - trial_s;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_SMUL1: begin
        t_r <= prod1[N+31:F];
        neg_r <= usel[N-1];
      end
      ST_SMUL2: begin
        mag_r <= 35'((prod2 + 49'd8192) >> 14);
      end
      ST_SOUT: begin
      end
      default: begin
      end
    endcase
    if (out_ld) begin
      sample_r <= sat;
      pair_end_r <= sel_b_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_gauss_sample = sample_r;
  assign out_pair_end = pair_end_r;

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_NORM) |-> (v_r != '0))
    else $error("normalize entered with zero W");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (rem_r < m_r))
    else $error("divider remainder not below divisor");

  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SMUL1) |-> (root_r[63:32] == '0))
    else $error("square root wider than 32 bits");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == ST_NORM))
    else $error("queue pop did not start a pair");

endmodule

`default_nettype wire
